FILE: hw/rtl/rle565_base64_encoder_assert.svh
// Assertion macros for the RLE565 base64 encoder.
// Each file that checks its own logic takes this header by include.
`ifndef RLE565_BASE64_ENCODER_ASSERT_SVH
`define RLE565_BASE64_ENCODER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define RLE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define RLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rle565b64_pkg.sv
// Shared types, constants and the base64 alphabet for the RLE565 encoder.
// No dependencies; every RTL file of the block refers to it by scoped name.
`default_nettype none

package rle565b64_pkg;

    // Run and character constants
    localparam logic [15:0] RUN_MAX     = 16'hFFFF;
    localparam logic [7:0]  LINE_RESET  = 8'd76;
    localparam logic [7:0]  LINE_MIN    = 8'd12;
    localparam logic [7:0]  CHAR_PAD    = 8'h3D;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CHAR_UPPER  = 8'h41;
    localparam logic [7:0]  CHAR_LOWER  = 8'h61;
    localparam logic [7:0]  CHAR_DIGIT  = 8'h30;
    localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
    localparam logic [7:0]  CHAR_SLASH  = 8'h2F;

    // Input word: one pixel
    typedef struct packed {
        logic [15:0] pixel;
        logic        last_pixel;
    } t_pixel_in;

    // Output word: one character
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char_out;

    // One finished run
    typedef struct packed {
        logic [15:0] count;
        logic [15:0] value;
    } t_run;

    // Command from the front to the back: an optional closed run, then
    // on the frame's last pixel the final run and padding
    typedef struct packed {
        logic close_valid;
        t_run close_run;
        logic last;
        t_run last_run;
    } t_cmd;

    // One four-character group, sextet 0 goes out first
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [1:0]      n_pad;
        logic            lf;
        logic            last;
    } t_group;

    // Map a sextet to its character in the standard alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] v;
        v = {2'b00, s};
        if (s < 6'd26) begin
            b64_char = CHAR_UPPER + v;
        end else if (s < 6'd52) begin
            b64_char = CHAR_LOWER + v - 8'd26;
        end else if (s < 6'd62) begin
            b64_char = CHAR_DIGIT + v - 8'd52;
        end else if (s == 6'd62) begin
            b64_char = CHAR_PLUS;
        end else begin
            b64_char = CHAR_SLASH;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rle565_base64_encoder.sv
// Path: a closed run goes through the command queue, the packer, the group register and
// the output register; whether its bytes complete a group depends on the bytes carried.
// Throughput: one pixel per cycle while the command queue has room; a closed run is four
// bytes, 4 or 8 characters plus any line feed, which the emitter sends one at a time.
// Reset: run, carry and line position clear, queues empty, line length 76.
// Depends on rle565b64_pkg and the front, cmdq, pack and emit modules.
`default_nettype none

module rle565_base64_encoder #(
    parameter int CMD_DEPTH = 2
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       push,
    output logic                      full,
    input  rle565b64_pkg::t_pixel_in  i_in,
    output logic                      empty,
    input  wire                       pop,
    output rle565b64_pkg::t_char_out  o_out,
    input  wire                       i_cfg_we,
    input  wire  [7:0]                i_cfg_wdata
);

    logic [7:0]            r_line_len;
    logic                  accept;
    logic                  cmd_push, cmd_full, cmd_pop, cmd_empty;
    rle565b64_pkg::t_cmd   cmd_in, cmd_head;
    logic                  grp_valid, grp_take;
    rle565b64_pkg::t_group grp;

    // Hold the line length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= rle565b64_pkg::LINE_RESET;
        end else if (i_cfg_we) begin
            r_line_len <= i_cfg_wdata;
        end
    end

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    rle565b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_in       (i_in),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rle565b64_cmdq #(
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    rle565b64_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmd_empty),
        .i_cmd         (cmd_head),
        .o_cmd_pop     (cmd_pop),
        .i_line_length (r_line_len),
        .i_grp_take    (grp_take),
        .o_grp_valid   (grp_valid),
        .o_grp         (grp)
    );

    rle565b64_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_grp_take  (grp_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rle565b64_front.sv
// Front end: tracks the open run and classifies each pixel.
// Depends on rle565b64_pkg; pushes run commands into rle565b64_cmdq.
`default_nettype none

module rle565b64_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  rle565b64_pkg::t_pixel_in i_in,
    output logic                     o_cmd_push,
    output rle565b64_pkg::t_cmd      o_cmd
);

    logic [15:0] r_value, n_value;
    logic [15:0] r_count, n_count;
    logic        close;

    // Extend, close or open the run; flush everything on the last pixel
    always_comb begin
        n_value = r_value;
        n_count = r_count;
        close   = 1'b0;
        if (r_count == 16'd0) begin
            n_value = i_in.pixel;
            n_count = 16'd1;
        end else if (i_in.pixel == r_value && r_count != rle565b64_pkg::RUN_MAX) begin
            n_count = r_count + 16'd1;
        end else begin
            close   = 1'b1;
            n_value = i_in.pixel;
            n_count = 16'd1;
        end
        o_cmd.close_valid    = close;
        o_cmd.close_run.count = r_count;
        o_cmd.close_run.value = r_value;
        o_cmd.last           = i_in.last_pixel;
        o_cmd.last_run.count = n_count;
        o_cmd.last_run.value = n_value;
        if (i_in.last_pixel) begin
            n_count = 16'd0;
            n_value = 16'd0;
        end
    end

    assign o_cmd_push = i_valid && (close || i_in.last_pixel);

    // Hold run state between accepted words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 16'd0;
            r_count <= 16'd0;
        end else if (i_valid) begin
            r_value <= n_value;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rle565b64_cmdq.sv
// Short command queue between the front end and the byte packer.
// Depends on rle565b64_pkg for the command type.
`default_nettype none

module rle565b64_cmdq #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  rle565b64_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire                 i_pop,
    output logic                o_empty,
    output rle565b64_pkg::t_cmd o_head
);

    `include "rle565_base64_encoder_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rle565b64_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RLE_ASSERT_ALWAYS(a_cmdq_level, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

FILE: hw/rtl/rle565b64_pack.sv
// Byte packer: walks a command's run bytes, builds base64 groups and
// line feeds, pads at frame end. Depends on rle565b64_pkg.
`default_nettype none

module rle565b64_pack (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_empty,
    input  rle565b64_pkg::t_cmd   i_cmd,
    output logic                  o_cmd_pop,
    input  wire  [7:0]            i_line_length,
    input  wire                   i_grp_take,
    output logic                  o_grp_valid,
    output rle565b64_pkg::t_group o_grp
);

    `include "rle565_base64_encoder_assert.svh"

    logic                  r_cmd_valid, n_cmd_valid;
    rle565b64_pkg::t_cmd   r_cmd;
    logic [2:0]            r_bidx, n_bidx;
    logic                  r_pad, n_pad;
    logic [15:0]           r_carry, n_carry;
    logic [1:0]            r_carry_cnt, n_carry_cnt;
    logic [7:0]            r_line_cnt, n_line_cnt;
    logic                  r_grp_valid;
    rle565b64_pkg::t_group r_grp, n_grp;

    logic [7:0]            eff_len;
    rle565b64_pkg::t_run   run_sel;
    logic [7:0]            cur_byte;
    logic [23:0]           triple;
    logic [8:0]            line_sum;
    logic                  lf_hit, slot_free, full_grp, need_grp, step;
    logic                  final_byte, end_nonlast, produce, done;

    // Pick the byte under the cursor
    always_comb begin
        run_sel = r_bidx[2] ? r_cmd.last_run : r_cmd.close_run;
        case (r_bidx[1:0])
            2'd0:    cur_byte = run_sel.count[7:0];
            2'd1:    cur_byte = run_sel.count[15:8];
            2'd2:    cur_byte = run_sel.value[7:0];
            2'd3:    cur_byte = run_sel.value[15:8];
            default: cur_byte = run_sel.value[15:8];
        endcase
    end

    assign eff_len     = (i_line_length < rle565b64_pkg::LINE_MIN) ?
                         rle565b64_pkg::LINE_MIN : i_line_length;
    assign triple      = {r_carry, cur_byte};
    assign line_sum    = {1'b0, r_line_cnt} + 9'd4;
    assign lf_hit      = (line_sum >= {1'b0, eff_len});
    assign slot_free   = !r_grp_valid || i_grp_take;
    assign full_grp    = !r_pad && (r_carry_cnt == 2'd2);
    assign need_grp    = r_pad || full_grp;
    assign step        = r_cmd_valid && (!need_grp || slot_free);
    assign final_byte  = (r_bidx == 3'd7);
    assign end_nonlast = (r_bidx == 3'd3) && !r_cmd.last;

    // Absorb a byte, complete a group, or emit the padded tail
    always_comb begin
        n_bidx      = r_bidx;
        n_pad       = r_pad;
        n_carry     = r_carry;
        n_carry_cnt = r_carry_cnt;
        n_line_cnt  = r_line_cnt;
        n_grp       = r_grp;
        produce     = 1'b0;
        done        = 1'b0;
        if (step) begin
            if (r_pad) begin
                produce        = 1'b1;
                done           = 1'b1;
                n_pad          = 1'b0;
                n_grp.lf       = 1'b0;
                n_grp.last     = 1'b1;
                n_grp.sextet[3] = 6'd0;
                if (r_carry_cnt == 2'd1) begin
                    n_grp.sextet[0] = r_carry[7:2];
                    n_grp.sextet[1] = {r_carry[1:0], 4'd0};
                    n_grp.sextet[2] = 6'd0;
                    n_grp.n_pad     = 2'd2;
                end else begin
                    n_grp.sextet[0] = r_carry[15:10];
                    n_grp.sextet[1] = r_carry[9:4];
                    n_grp.sextet[2] = {r_carry[3:0], 2'd0};
                    n_grp.n_pad     = 2'd1;
                end
                n_carry     = 16'd0;
                n_carry_cnt = 2'd0;
                n_line_cnt  = 8'd0;
            end else if (full_grp) begin
                produce         = 1'b1;
                n_grp.sextet[0] = triple[23:18];
                n_grp.sextet[1] = triple[17:12];
                n_grp.sextet[2] = triple[11:6];
                n_grp.sextet[3] = triple[5:0];
                n_grp.n_pad     = 2'd0;
                n_grp.lf        = lf_hit;
                n_grp.last      = final_byte;
                n_carry         = 16'd0;
                n_carry_cnt     = 2'd0;
                n_line_cnt      = lf_hit ? 8'd0 : line_sum[7:0];
                if (final_byte) begin
                    done       = 1'b1;
                    n_line_cnt = 8'd0;
                end else if (end_nonlast) begin
                    done = 1'b1;
                end else begin
                    n_bidx = r_bidx + 3'd1;
                end
            end else begin
                n_carry     = {r_carry[7:0], cur_byte};
                n_carry_cnt = r_carry_cnt + 2'd1;
                if (final_byte) begin
                    n_pad = 1'b1;
                end else if (end_nonlast) begin
                    done = 1'b1;
                end else begin
                    n_bidx = r_bidx + 3'd1;
                end
            end
        end
    end

    assign o_cmd_pop   = !i_cmd_empty && (!r_cmd_valid || done);
    assign o_grp_valid = r_grp_valid;
    assign o_grp       = r_grp;

    always_comb begin
        if (o_cmd_pop) begin
            n_cmd_valid = 1'b1;
        end else if (done) begin
            n_cmd_valid = 1'b0;
        end else begin
            n_cmd_valid = r_cmd_valid;
        end
    end

    // Load commands and group payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (produce) begin
            r_grp <= n_grp;
        end
    end

    // Advance the cursor, carry and line position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_bidx      <= 3'd0;
            r_pad       <= 1'b0;
            r_carry     <= 16'd0;
            r_carry_cnt <= 2'd0;
            r_line_cnt  <= 8'd0;
            r_grp_valid <= 1'b0;
        end else begin
            r_cmd_valid <= n_cmd_valid;
            r_carry     <= n_carry;
            r_carry_cnt <= n_carry_cnt;
            r_line_cnt  <= n_line_cnt;
            if (o_cmd_pop) begin
                r_bidx <= i_cmd.close_valid ? 3'd0 : 3'd4;
                r_pad  <= 1'b0;
            end else begin
                r_bidx <= n_bidx;
                r_pad  <= n_pad;
            end
            if (produce) begin
                r_grp_valid <= 1'b1;
            end else if (i_grp_take) begin
                r_grp_valid <= 1'b0;
            end
        end
    end

    `RLE_ASSERT_ALWAYS(a_pack_carry, i_clk, i_rst_n,
        r_carry_cnt != 2'd3, "carry count out of range")
    `RLE_ASSERT_IMPLY(a_pack_padfill, i_clk, i_rst_n,
        r_pad, r_carry_cnt != 2'd0, "pad with no carry")
    `RLE_ASSERT_NEXT(a_pack_frame_end, i_clk, i_rst_n, produce && n_grp.last,
        (r_carry_cnt == 2'd0) && (r_line_cnt == 8'd0), "state not cleared at frame end")

endmodule

`default_nettype wire

FILE: hw/rtl/rle565b64_emit.sv
// Character emitter: sends one group's characters and any line feed one per cycle
// while the output register is free or popped. Depends on rle565b64_pkg.
`default_nettype none

module rle565b64_emit (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_grp_valid,
    input  rle565b64_pkg::t_group     i_grp,
    output logic                      o_grp_take,
    input  wire                       i_pop,
    output logic                      o_empty,
    output rle565b64_pkg::t_char_out  o_out
);

    `include "rle565_base64_encoder_assert.svh"

    logic                     r_busy;
    rle565b64_pkg::t_group    r_grp;
    logic [2:0]               r_pos;
    logic                     r_out_valid;
    rle565b64_pkg::t_char_out r_out, n_out;
    logic [2:0]               last_pos;
    logic [2:0]               pad_sum;
    logic                     advance, finishing;

    assign last_pos   = r_grp.lf ? 3'd4 : 3'd3;
    assign advance    = r_busy && (!r_out_valid || i_pop);
    assign finishing  = advance && (r_pos == last_pos);
    assign o_grp_take = i_grp_valid && (!r_busy || finishing);
    assign pad_sum    = {1'b0, r_pos[1:0]} + {1'b0, r_grp.n_pad};
    assign o_empty    = !r_out_valid;
    assign o_out      = r_out;

    // Select the character at the cursor
    always_comb begin
        if (r_pos == 3'd4) begin
            n_out.char_code = rle565b64_pkg::CHAR_LF;
        end else if (pad_sum >= 3'd4) begin
            n_out.char_code = rle565b64_pkg::CHAR_PAD;
        end else begin
            n_out.char_code = rle565b64_pkg::b64_char(r_grp.sextet[r_pos[1:0]]);
        end
        n_out.last_char = r_grp.last && (r_pos == last_pos);
    end

    // Hold group and output payload
    always_ff @(posedge i_clk) begin
        if (o_grp_take) begin
            r_grp <= i_grp;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Step through the group, drop the output word once popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_grp_take) begin
                r_busy <= 1'b1;
                r_pos  <= 3'd0;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_pos <= r_pos + 3'd1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `RLE_ASSERT_IMPLY(a_emit_pos, i_clk, i_rst_n, r_busy, r_pos <= last_pos, "cursor past end of group")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rle565_base64_encoder: pixel words in, base64 character words out.
// Depends on rle565b64_pkg and the encoder RTL; holds its own run, byte-packing and line model.

import rle565b64_pkg::*;

// Predicts the character stream and checks each popped character word
class rle_char_scoreboard;
    string        alphabet;
    t_char_out    expected_chars[$];
    logic [7:0]   line_length;
    logic [15:0]  run_value;
    logic [15:0]  run_count;
    logic [15:0]  carry_bytes;
    int unsigned  carry_count;
    int unsigned  line_count;
    int unsigned  step_chars;
    int unsigned  errors;

    function new();
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        line_length = LINE_RESET;
        errors = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        run_value = '0;
        run_count = '0;
        carry_bytes = '0;
        carry_count = 0;
        line_count = 0;
    endfunction

    // Queue one character, capped per pixel
    function void add_char(logic [7:0] c);
        t_char_out w;
        if (step_chars < 17) begin
            w.char_code = c;
            w.last_char = 1'b0;
            expected_chars.push_back(w);
            step_chars++;
        end
    endfunction

    function logic [7:0] sextet_char(logic [23:0] triple, int unsigned shift);
        logic [5:0] idx;
        idx = 6'(triple >> shift);
        return alphabet[idx];
    endfunction

    // Collect bytes into groups of three, emit four characters and any line feed
    function void pack_byte(logic [7:0] b);
        logic [23:0] triple;
        int unsigned eff;
        if (carry_count < 2) begin
            carry_bytes = {carry_bytes[7:0], b};
            carry_count++;
            return;
        end
        triple = {carry_bytes, b};
        add_char(sextet_char(triple, 18));
        add_char(sextet_char(triple, 12));
        add_char(sextet_char(triple, 6));
        add_char(sextet_char(triple, 0));
        carry_bytes = '0;
        carry_count = 0;
        eff = 32'((line_length < LINE_MIN) ? LINE_MIN : line_length);
        line_count += 4;
        if (line_count >= eff) begin
            add_char(CHAR_LF);
            line_count = 0;
        end
    endfunction

    // Count low byte first, then value low byte first
    function void close_run();
        pack_byte(run_count[7:0]);
        pack_byte(run_count[15:8]);
        pack_byte(run_value[7:0]);
        pack_byte(run_value[15:8]);
    endfunction

    // Flush a partial group with '=' padding
    function void pad_group();
        logic [23:0] triple;
        if (carry_count == 0) begin
            return;
        end
        triple = (carry_count == 1) ? {carry_bytes[7:0], 16'h0000} : {carry_bytes, 8'h00};
        add_char(sextet_char(triple, 18));
        add_char(sextet_char(triple, 12));
        add_char((carry_count > 1) ? sextet_char(triple, 6) : CHAR_PAD);
        add_char(CHAR_PAD);
    endfunction

    // Advance the model by one accepted pixel word
    function void note_pixel(t_pixel_in w);
        t_char_out tail;
        step_chars = 0;
        if (run_count == 0) begin
            run_value = w.pixel;
            run_count = 16'd1;
        end else if (w.pixel == run_value && run_count < RUN_MAX) begin
            run_count++;
        end else begin
            close_run();
            run_value = w.pixel;
            run_count = 16'd1;
        end
        if (w.last_pixel) begin
            close_run();
            pad_group();
            clear_stream();
            if (step_chars > 0) begin
                tail = expected_chars.pop_back();
                tail.last_char = 1'b1;
                expected_chars.push_back(tail);
            end
        end
    endfunction

    // Compare one popped character word with the oldest prediction
    function void check_char(t_char_out got);
        t_char_out want;
        if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual char %h last %b",
                     $time, got.char_code, got.last_char);
            return;
        end
        want = expected_chars.pop_front();
        if (got.char_code !== want.char_code) begin
            errors++;
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.char_code, got.char_code);
        end
        if (got.last_char !== want.last_char) begin
            errors++;
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last_char, got.last_char);
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    wire         full;
    t_pixel_in   i_in;
    wire         empty;
    logic        pop;
    t_char_out   o_out;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;

    int unsigned         gap_pct;
    int unsigned         cycle_count;
    rle_char_scoreboard  char_board;

    rle565_base64_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one pixel word after a random gap, hold until accepted
    task automatic send_pixel(input logic [15:0] px, input logic last);
        t_pixel_in w;
        w.pixel = px;
        w.last_pixel = last;
        while ($urandom_range(0, 99) < gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= w;
        do begin
            @(posedge i_clk);
        end while (full);
        char_board.note_pixel(w);
    endtask

    // Drop push and wait for every predicted character, then let the pipe settle
    task automatic drain_results();
        push <= 1'b0;
        while (char_board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        char_board.line_length = value;
    endtask

    // Runs of random length and value, frames closed now and then
    task automatic random_runs(input int n_items);
        int          sent;
        int          run_len;
        int          roll;
        logic [15:0] value;
        logic [15:0] prev_value;
        bit          end_frame;
        bit          stray_last;
        sent = 0;
        prev_value = '0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                run_len = $urandom_range(1, 4);
            end else if (roll < 98) begin
                run_len = $urandom_range(5, 20);
            end else begin
                run_len = $urandom_range(250, 270);
            end
            // Keep the phase to its item budget
            if (run_len > n_items - sent) begin
                run_len = n_items - sent;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                value = 16'h0000;
            end else if (roll < 20) begin
                value = 16'hFFFF;
            end else if (roll < 28) begin
                value = prev_value;
            end else begin
                value = $urandom;
            end
            end_frame = ($urandom_range(0, 99) < 15);
            for (int k = 0; k < run_len; k++) begin
                stray_last = ($urandom_range(0, 199) == 0);
                send_pixel(value, (end_frame && k == run_len - 1) || stray_last);
            end
            prev_value = value;
            sent += run_len;
        end
    endtask

    // Cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: pop at random, check every accepted character word
    initial begin
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pop <= ($urandom_range(0, 99) >= gap_pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                char_board.check_char(o_out);
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0] line_settings [9];
        char_board = new();
        gap_pct = 37;
        push = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset line length: single-run, two-run and three-run frames cover
        // two pads, one pad and none; then a fresh frame after the end
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hA5A5, 1'b0);
        send_pixel(16'h5A5A, 1'b0);
        send_pixel(16'hA5A5, 1'b1);
        send_pixel(16'h8001, 1'b1);
        drain_results();

        // Line of sixteen: three runs fill it exactly, so the frame ends on a line feed
        write_line_length(8'd16);
        send_pixel(16'h1111, 1'b0);
        send_pixel(16'h2222, 1'b0);
        send_pixel(16'h3333, 1'b1);
        send_pixel(16'h7E00, 1'b0);
        send_pixel(16'h01FF, 1'b1);
        drain_results();

        // Random phases over a spread of line lengths, one without any gaps
        line_settings = '{8'd4, 8'd252, 8'd0, 8'd255, 8'd30, 8'd12, 8'd13, 8'd76, 8'd8};
        for (int p = 0; p < 9; p++) begin
            write_line_length(line_settings[p]);
            gap_pct = (p == 2) ? 0 : 37;
            random_runs(22);
            drain_results();
        end

        if (char_board.errors == 0 && char_board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rle565b64_pkg.sv
hw/rtl/rle565b64_front.sv
hw/rtl/rle565b64_cmdq.sv
hw/rtl/rle565b64_pack.sv
hw/rtl/rle565b64_emit.sv
hw/rtl/rle565_base64_encoder.sv
verif/tb_top.sv
